// ===== src/lav_pkg.sv =====
`timescale 1ns / 1ps

package lav_pkg;

  // Job queue depth between the front and the back
  localparam int QUEUE_DEPTH = 2;
  localparam int ONE_Q16     = 65536;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } in_t;

  typedef struct packed {
    logic        [1:0]  column_index;
    logic signed [31:0] row0_value;
    logic signed [31:0] row1_value;
    logic signed [31:0] row2_value;
    logic signed [31:0] row3_value;
    logic               last_column;
  } out_t;

  // Queued job: eye, up hint and the exact 33-bit difference target - eye
  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
    logic signed [32:0] d_x;
    logic signed [32:0] d_y;
    logic signed [32:0] d_z;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NMAX,
    ST_NSHIFT,
    ST_MUL,
    ST_ACC,
    ST_SQRT,
    ST_DINIT,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    MAC_SQ,
    MAC_FXUP,
    MAC_SXF,
    MAC_DOTS,
    MAC_DOTU,
    MAC_DOTF
  } mac_t;

  // Q32.32 to Q16.16, nearest, ties away from zero
  function automatic logic signed [63:0] round16(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + 64'd32768) >> 16;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

// ===== src/lav_front.sv =====
`timescale 1ns / 1ps

module lav_front #(
  parameter int DEPTH = lav_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  lav_pkg::in_t   item,
  input  logic           pop,
  output logic           job_valid,
  output lav_pkg::job_t  job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lav_pkg::job_t  slots [DEPTH];
  lav_pkg::job_t  job_new;
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           take;

  // exact difference at 33 bits
  always_comb begin
    job_new.eye_x = item.eye_x;
    job_new.eye_y = item.eye_y;
    job_new.eye_z = item.eye_z;
    job_new.up_x  = item.up_x;
    job_new.up_y  = item.up_y;
    job_new.up_z  = item.up_z;
    job_new.d_x   = 33'(item.target_x) - 33'(item.eye_x);
    job_new.d_y   = 33'(item.target_y) - 33'(item.eye_y);
    job_new.d_z   = 33'(item.target_z) - 33'(item.eye_z);
  end

  assign busy      = (count == CW'(DEPTH));
  assign push      = start && !busy;
  assign job_valid = (count != '0);
  assign take      = pop && job_valid;
  assign job       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/lav_back.sv =====
`timescale 1ns / 1ps

module lav_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  lav_pkg::job_t  job,
  output logic           pop,
  output logic           strobe,
  output lav_pkg::out_t  result
);

  lav_pkg::state_t state, state_next;
  lav_pkg::mac_t   mac;

  logic [2:0]  k;
  logic [5:0]  cnt;
  logic [1:0]  col;
  logic        pass;

  logic signed [31:0] eye [3];
  logic signed [31:0] up  [3];
  logic signed [63:0] nv  [3];
  logic        [63:0] mag [3];
  logic        [63:0] mmax;
  logic signed [19:0] fv  [3];
  logic signed [19:0] sv  [3];
  logic signed [19:0] uv  [3];
  logic signed [31:0] c3  [3];

  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic        [63:0] sq_x;
  logic        [63:0] sq_res;
  logic        [63:0] sq_bit;
  logic        [31:0] drem;
  logic        [17:0] dlow;
  logic        [17:0] dq;

  // combinational helpers
  logic        [63:0] mag_c [3];
  logic        [63:0] mmax_c;
  logic        [1:0]  j, ia, ib, i1, i2;
  logic signed [32:0] opa, opb;
  logic               neg;
  logic signed [63:0] acc_sum;
  logic               cross_op;
  logic               last_term;
  logic        [63:0] sq_trial;
  logic        [63:0] mag_k;
  logic               sign_k;
  logic        [46:0] num;
  logic        [31:0] trial;
  logic               ge;
  logic        [17:0] q;
  logic signed [19:0] q_s;

  function automatic logic signed [32:0] pick3(input logic [1:0] i,
                                               input logic signed [32:0] v0,
                                               input logic signed [32:0] v1,
                                               input logic signed [32:0] v2);
    logic signed [32:0] r;
    case (i)
      2'd0:    r = v0;
      2'd1:    r = v1;
      default: r = v2;
    endcase
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = nv[i][63] ? 64'(-nv[i]) : 64'(nv[i]);
    end
    mmax_c = mag_c[0];
    if (mag_c[1] > mmax_c) mmax_c = mag_c[1];
    if (mag_c[2] > mmax_c) mmax_c = mag_c[2];
  end

  // cross component j = a[i1]*b[i2] - a[i2]*b[i1]
  always_comb begin
    j = k[2:1];
    case (j)
      2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
      2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
      default: begin i1 = 2'd0; i2 = 2'd1; end
    endcase
    ia = k[0] ? i2 : i1;
    ib = k[0] ? i1 : i2;
  end

  always_comb begin
    case (k[1:0])
      2'd0:    begin mag_k = mag[0]; sign_k = nv[0][63]; end
      2'd1:    begin mag_k = mag[1]; sign_k = nv[1][63]; end
      default: begin mag_k = mag[2]; sign_k = nv[2][63]; end
    endcase
  end

  always_comb begin
    opa = '0;
    opb = '0;
    neg = 1'b0;
    case (mac)
      lav_pkg::MAC_SQ: begin
        opa = {3'b000, mag_k[29:0]};
        opb = {3'b000, mag_k[29:0]};
      end
      lav_pkg::MAC_FXUP: begin
        opa = pick3(ia, 33'(fv[0]), 33'(fv[1]), 33'(fv[2]));
        opb = pick3(ib, 33'(up[0]), 33'(up[1]), 33'(up[2]));
        neg = k[0];
      end
      lav_pkg::MAC_SXF: begin
        opa = pick3(ia, 33'(sv[0]), 33'(sv[1]), 33'(sv[2]));
        opb = pick3(ib, 33'(fv[0]), 33'(fv[1]), 33'(fv[2]));
        neg = k[0];
      end
      lav_pkg::MAC_DOTS: begin
        opa = pick3(k[1:0], 33'(sv[0]), 33'(sv[1]), 33'(sv[2]));
        opb = pick3(k[1:0], 33'(eye[0]), 33'(eye[1]), 33'(eye[2]));
        neg = 1'b1;
      end
      lav_pkg::MAC_DOTU: begin
        opa = pick3(k[1:0], 33'(uv[0]), 33'(uv[1]), 33'(uv[2]));
        opb = pick3(k[1:0], 33'(eye[0]), 33'(eye[1]), 33'(eye[2]));
        neg = 1'b1;
      end
      lav_pkg::MAC_DOTF: begin
        opa = pick3(k[1:0], 33'(fv[0]), 33'(fv[1]), 33'(fv[2]));
        opb = pick3(k[1:0], 33'(eye[0]), 33'(eye[1]), 33'(eye[2]));
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  assign acc_sum   = acc + (neg ? -prod : prod);
  assign cross_op  = (mac == lav_pkg::MAC_FXUP) || (mac == lav_pkg::MAC_SXF);
  assign last_term = cross_op ? (k == 3'd5) : (k == 3'd2);
  assign sq_trial  = sq_res + sq_bit;
  assign num       = 47'({mag_k[29:0], 16'h0000}) + 47'(sq_res[31:1]);
  assign trial     = {drem[30:0], dlow[17]};
  assign ge        = (trial >= sq_res[31:0]);
  assign q         = {dq[16:0], ge};
  assign q_s       = sign_k ? -20'(q) : 20'(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lav_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    strobe     = 1'b0;
    unique case (state)
      lav_pkg::ST_IDLE: begin
        if (job_valid) begin
          pop        = 1'b1;
          state_next = lav_pkg::ST_NMAX;
        end
      end
      lav_pkg::ST_NMAX: begin
        state_next = (mmax_c == '0) ? lav_pkg::ST_MUL : lav_pkg::ST_NSHIFT;
      end
      lav_pkg::ST_NSHIFT: begin
        if (!(|mmax[63:30]) && mmax[29]) begin
          state_next = lav_pkg::ST_MUL;
        end
      end
      lav_pkg::ST_MUL: begin
        state_next = lav_pkg::ST_ACC;
      end
      lav_pkg::ST_ACC: begin
        if (last_term) begin
          case (mac)
            lav_pkg::MAC_SQ:   state_next = lav_pkg::ST_SQRT;
            lav_pkg::MAC_FXUP: state_next = lav_pkg::ST_NMAX;
            lav_pkg::MAC_DOTF: state_next = lav_pkg::ST_EMIT;
            default:           state_next = lav_pkg::ST_MUL;
          endcase
        end else begin
          state_next = lav_pkg::ST_MUL;
        end
      end
      lav_pkg::ST_SQRT: begin
        if (cnt == 6'd31) state_next = lav_pkg::ST_DINIT;
      end
      lav_pkg::ST_DINIT: begin
        state_next = lav_pkg::ST_DIV;
      end
      lav_pkg::ST_DIV: begin
        if (cnt == 6'd17) begin
          state_next = (k == 3'd2) ? lav_pkg::ST_MUL : lav_pkg::ST_DINIT;
        end
      end
      lav_pkg::ST_EMIT: begin
        strobe = 1'b1;
        if (col == 2'd3) state_next = lav_pkg::ST_IDLE;
      end
      default: begin
        state_next = lav_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      lav_pkg::ST_IDLE: begin
        eye[0] <= job.eye_x;
        eye[1] <= job.eye_y;
        eye[2] <= job.eye_z;
        up[0]  <= job.up_x;
        up[1]  <= job.up_y;
        up[2]  <= job.up_z;
        nv[0]  <= 64'(job.d_x);
        nv[1]  <= 64'(job.d_y);
        nv[2]  <= 64'(job.d_z);
        pass   <= 1'b0;
        col    <= 2'd0;
      end
      lav_pkg::ST_NMAX: begin
        for (int i = 0; i < 3; i++) begin
          mag[i] <= mag_c[i];
        end
        mmax <= mmax_c;
        if (mmax_c == '0) begin
          // zero length: result is the zero vector
          for (int i = 0; i < 3; i++) begin
            if (pass) sv[i] <= '0;
            else      fv[i] <= '0;
          end
          mac <= pass ? lav_pkg::MAC_SXF : lav_pkg::MAC_FXUP;
          k   <= '0;
          acc <= '0;
        end
      end
      lav_pkg::ST_NSHIFT: begin
        if (|mmax[63:30]) begin
          mmax <= mmax >> 1;
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end else if (!mmax[29]) begin
          mmax <= mmax << 1;
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
        end else begin
          mac <= lav_pkg::MAC_SQ;
          k   <= '0;
          acc <= '0;
        end
      end
      lav_pkg::ST_MUL: begin
        prod <= 64'(opa) * 64'(opb);
      end
      lav_pkg::ST_ACC: begin
        if (cross_op && k[0]) begin
          acc <= '0;
          if (mac == lav_pkg::MAC_FXUP) nv[j] <= acc_sum;
          else                          uv[j] <= 20'(lav_pkg::round16(acc_sum));
        end else begin
          acc <= acc_sum;
        end
        if (last_term) begin
          case (mac)
            lav_pkg::MAC_SQ: begin
              sq_x   <= 64'(acc_sum);
              sq_res <= '0;
              sq_bit <= 64'(1) << 62;
              cnt    <= '0;
            end
            lav_pkg::MAC_FXUP: begin
              pass <= 1'b1;
            end
            lav_pkg::MAC_SXF: begin
              mac <= lav_pkg::MAC_DOTS;
              k   <= '0;
            end
            lav_pkg::MAC_DOTS: begin
              c3[0] <= lav_pkg::sat32(lav_pkg::round16(acc_sum));
              mac   <= lav_pkg::MAC_DOTU;
              k     <= '0;
              acc   <= '0;
            end
            lav_pkg::MAC_DOTU: begin
              c3[1] <= lav_pkg::sat32(lav_pkg::round16(acc_sum));
              mac   <= lav_pkg::MAC_DOTF;
              k     <= '0;
              acc   <= '0;
            end
            default: begin
              c3[2] <= lav_pkg::sat32(lav_pkg::round16(acc_sum));
              acc   <= '0;
            end
          endcase
        end else begin
          k <= k + 1'b1;
        end
      end
      lav_pkg::ST_SQRT: begin
        if (sq_x >= sq_trial) begin
          sq_x   <= sq_x - sq_trial;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        cnt    <= cnt + 1'b1;
        k      <= '0;
      end
      lav_pkg::ST_DINIT: begin
        drem <= 32'(num[46:18]);
        dlow <= num[17:0];
        dq   <= '0;
        cnt  <= '0;
      end
      lav_pkg::ST_DIV: begin
        drem <= ge ? trial - sq_res[31:0] : trial;
        dq   <= q;
        dlow <= {dlow[16:0], 1'b0};
        cnt  <= cnt + 1'b1;
        if (cnt == 6'd17) begin
          if (pass) sv[k[1:0]] <= q_s;
          else      fv[k[1:0]] <= q_s;
          if (k == 3'd2) begin
            mac <= pass ? lav_pkg::MAC_SXF : lav_pkg::MAC_FXUP;
            k   <= '0;
            acc <= '0;
          end else begin
            k <= k + 1'b1;
          end
        end
      end
      lav_pkg::ST_EMIT: begin
        col <= col + 1'b1;
      end
      default: begin
        col <= col;
      end
    endcase
  end

  always_comb begin
    result.column_index = col;
    result.last_column  = (col == 2'd3);
    case (col)
      2'd0: begin
        result.row0_value = 32'(sv[0]);
        result.row1_value = 32'(uv[0]);
        result.row2_value = -32'(fv[0]);
        result.row3_value = '0;
      end
      2'd1: begin
        result.row0_value = 32'(sv[1]);
        result.row1_value = 32'(uv[1]);
        result.row2_value = -32'(fv[1]);
        result.row3_value = '0;
      end
      2'd2: begin
        result.row0_value = 32'(sv[2]);
        result.row1_value = 32'(uv[2]);
        result.row2_value = -32'(fv[2]);
        result.row3_value = '0;
      end
      default: begin
        result.row0_value = c3[0];
        result.row1_value = c3[1];
        result.row2_value = c3[2];
        result.row3_value = 32'(lav_pkg::ONE_Q16);
      end
    endcase
  end

endmodule

// ===== src/look_at_view_matrix_top.sv =====
`timescale 1ns / 1ps

// Each normalisation aligns by 0..29 shifts; zero-length vectors skip that work.
// Transactions are handled one at a time by the shared bit-serial square root and
// divider, while the queue takes new ones until full; four column strobes follow on
// consecutive cycles.
// Reset: synchronous, active high; clears the queue and the sequencer.
// Results cannot be stalled: each column is valid for exactly one strobe cycle.

module look_at_view_matrix_top #(
  parameter int DEPTH = lav_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  lav_pkg::in_t   item,
  output logic           strobe,
  output lav_pkg::out_t  result
);

  // Front: takes transactions, forms target - eye, queues them
  logic          job_valid;
  logic          pop;
  lav_pkg::job_t job;

  lav_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .pop       (pop),
    .job_valid (job_valid),
    .job       (job)
  );

  // Back: normalise, cross, normalise, cross, dot products, then four columns
  lav_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .pop       (pop),
    .strobe    (strobe),
    .result    (result)
  );

endmodule

// ===== src/lav_checker.sv =====
`timescale 1ns / 1ps

module lav_checker (
  input logic          clk,
  input logic          rst,
  input logic          strobe,
  input lav_pkg::out_t result
);

  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.last_column == (result.column_index == 2'd3)))
    else $error("last mark does not match column 3");

  a_col_seq: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.column_index != 2'd3) |=>
      (strobe && result.column_index == 2'($past(result.column_index) + 2'd1)))
    else $error("columns not consecutive");

  a_first_col: assert property (@(posedge clk) disable iff (rst)
    $rose(strobe) |-> (result.column_index == 2'd0))
    else $error("burst does not start at column 0");

  a_reset: assert property (@(posedge clk)
    rst |=> !strobe)
    else $error("strobe after reset");

endmodule

bind look_at_view_matrix_top lav_checker u_lav_checker (
  .clk    (clk),
  .rst    (rst),
  .strobe (strobe),
  .result (result)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           start = 1'b0;
  logic           busy;
  lav_pkg::in_t   item = '0;
  logic           strobe;
  lav_pkg::out_t  result;

  // Columns still to come, oldest first
  lav_pkg::out_t  columns_due[$];
  int    mismatches = 0;
  int    unexpected = 0;

  look_at_view_matrix_top DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Magnitude of a signed value
  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Floor square root, bit by bit
  function automatic logic [63:0] root64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q32.32 to Q16.16, nearest, ties away from zero
  function automatic logic signed [63:0] to_q16(input logic signed [63:0] v);
    logic [63:0] m;
    m = (abs64(v) + 64'd32768) >> 16;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  // Unit vector in Q16.16; zero length gives zero
  task automatic unit_vec(input logic signed [63:0] v[3], output logic signed [63:0] r[3]);
    logic [63:0] a[3];
    logic [63:0] m, sum, n, q;
    int rs, ls;
    m = 0; sum = 0; rs = 0; ls = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = abs64(v[i]);
      if (a[i] > m) m = a[i];
    end
    if (m == 0) begin
      for (int i = 0; i < 3; i++) r[i] = 0;
      return;
    end
    while (m >= (64'd1 << 30)) begin m = m >> 1; rs++; end
    while (m < (64'd1 << 29)) begin m = m << 1; ls++; end
    for (int i = 0; i < 3; i++) begin
      a[i] = (a[i] >> rs) << ls;
      sum = sum + a[i] * a[i];
    end
    n = root64(sum);
    for (int i = 0; i < 3; i++) begin
      q = (a[i] * 64'd65536 + n / 2) / n;
      r[i] = v[i][63] ? -$signed(q) : $signed(q);
    end
  endtask

  task automatic cross_vec(input logic signed [63:0] a[3], input logic signed [63:0] b[3],
                           output logic signed [63:0] r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endtask

  function automatic logic signed [63:0] dot_vec(input logic signed [63:0] a[3],
                                                 input logic signed [63:0] b[3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  // Works out the four view-matrix columns for one camera and queues them
  task automatic predict_view(input lav_pkg::in_t c);
    logic signed [63:0] eye[3], up[3], d[3], f[3], sc[3], s[3], uc[3], u[3];
    logic signed [63:0] col3[3];
    lav_pkg::out_t o;
    eye[0] = c.eye_x; eye[1] = c.eye_y; eye[2] = c.eye_z;
    up[0] = c.up_x; up[1] = c.up_y; up[2] = c.up_z;
    d[0] = 64'(c.target_x) - 64'(c.eye_x);
    d[1] = 64'(c.target_y) - 64'(c.eye_y);
    d[2] = 64'(c.target_z) - 64'(c.eye_z);
    unit_vec(d, f);
    cross_vec(f, up, sc);
    unit_vec(sc, s);
    cross_vec(s, f, uc);
    for (int i = 0; i < 3; i++) u[i] = to_q16(uc[i]);
    col3[0] = clamp32(to_q16(-dot_vec(s, eye)));
    col3[1] = clamp32(to_q16(-dot_vec(u, eye)));
    col3[2] = clamp32(to_q16(dot_vec(f, eye)));
    for (int k = 0; k < 4; k++) begin
      o.column_index = 2'(k);
      o.last_column = (k == 3);
      if (k < 3) begin
        o.row0_value = 32'(s[k]);
        o.row1_value = 32'(u[k]);
        o.row2_value = 32'(-f[k]);
        o.row3_value = 0;
      end else begin
        o.row0_value = 32'(col3[0]);
        o.row1_value = 32'(col3[1]);
        o.row2_value = 32'(col3[2]);
        o.row3_value = 32'(lav_pkg::ONE_Q16);
      end
      columns_due.push_back(o);
    end
  endtask

  // Sends one transaction after a random gap; waits for acceptance.
  // start stays high after acceptance so back-to-back sends need not drop it in between.
  task automatic send_camera(input lav_pkg::in_t c);
    int gap;
    gap = $urandom_range(0, 5);
    // a few runs with no gap at all
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_view(c);
  endtask

  function automatic lav_pkg::in_t pack_cam(input logic signed [31:0] ex, ey, ez, tx, ty, tz,
                                            ux, uy, uz);
    lav_pkg::in_t c;
    c = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
    return c;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
      2: return $signed($urandom_range(0, 32'h02000000)) - 32'sh01000000;
      3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
    endcase
  endfunction

  // Checks each column against the oldest prediction
  always @(posedge clk) begin
    lav_pkg::out_t want;
    if (!rst && strobe) begin
      if (columns_due.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected column %0d", result.column_index);
      end else begin
        want = columns_due.pop_front();
        if (result !== want) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("column %0d: expected %h %h %h %h last %b, got col %0d %h %h %h %h last %b",
                     want.column_index, want.row0_value, want.row1_value, want.row2_value,
                     want.row3_value, want.last_column, result.column_index,
                     result.row0_value, result.row1_value, result.row2_value,
                     result.row3_value, result.last_column);
        end
      end
    end
  end

  localparam logic signed [31:0] ONE = 32'sh00010000;

  // Identity-like cameras, axis cases and the degenerate ones
  task automatic test_directed();
    send_camera(pack_cam(0, 0, 0, 0, 0, -ONE, 0, ONE, 0));
    send_camera(pack_cam(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0));
    // eye equals target: forward is zero
    send_camera(pack_cam(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0));
    // up parallel to forward: side is zero
    send_camera(pack_cam(0, 0, 0, 0, 4 * ONE, 0, 0, ONE, 0));
    send_camera(pack_cam(0, 0, 0, ONE, 0, 0, 0, 0, 0));
    // extremes: widest difference and saturating eye products
    send_camera(pack_cam(32'sh80000000, 32'sh80000000, 32'sh80000000,
                         32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                         32'sh7fffffff, 32'sh80000000, 32'sh00000001));
    send_camera(pack_cam(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                         32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                         32'sh80000000, 32'sh7fffffff, 32'sh80000000));
    send_camera(pack_cam(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0,
                         0, ONE, 0));
    send_camera(pack_cam(32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0,
                         ONE, 0, 0));
    // tiny vectors need left alignment
    send_camera(pack_cam(0, 0, 0, 1, 0, 0, 0, 0, 1));
    send_camera(pack_cam(0, 0, 0, -1, -1, -1, 1, -1, 0));
    send_camera(pack_cam(32'sh12345678, 32'shedcba987, 32'sh0f0f0f0f,
                         32'sh00000000, 32'shffffffff, 32'sh7f000000,
                         32'shfedcba98, 32'sh01234567, 32'shffff0000));
  endtask

  // Hold off until the block has drained completely
  task automatic test_drain_pause();
    start <= 1'b0;
    wait (columns_due.size() == 0);
    repeat (20) @(posedge clk);
    send_camera(pack_cam(ONE, ONE, ONE, -ONE, 3 * ONE, 7 * ONE, ONE, 0, ONE));
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++)
      send_camera(pack_cam(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                           rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                           rand_coord()));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(50);
    test_drain_pause();
    test_random(50);
    start <= 1'b0;
    wait (columns_due.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && unexpected == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // ~115 transactions, with margin
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lav_pkg.sv
src/lav_front.sv
src/lav_back.sv
src/look_at_view_matrix_top.sv
src/lav_checker.sv
test/testbench.sv
